>>> rtl/quoted_printable_decoder_unit_defines.svh
// Assertion macros for the quoted-printable decoder checker.
// Used by the checker file only; needs clk and rst_n in scope.
`ifndef QUOTED_PRINTABLE_DECODER_UNIT_DEFINES_SVH
`define QUOTED_PRINTABLE_DECODER_UNIT_DEFINES_SVH

// Implication in the same cycle, off while reset is asserted.
`define QPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle, off while reset is asserted.
`define QPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication in the next cycle that also covers the reset cycles.
`define QPD_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/qpd_pkg.sv
// Shared types, codes and the hex digit lookup for the quoted-printable decoder.
// No dependencies.
`default_nettype none

package qpd_pkg;

  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [1:0] PHASE_IDLE  = 2'd0;
  localparam logic [1:0] PHASE_EQ    = 2'd1;
  localparam logic [1:0] PHASE_DIGIT = 2'd2;

  localparam int QPD_FIFO_DEPTH = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } qpd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } qpd_out_t;

  // Up to two result items produced by one input item, oldest in r0.
  typedef struct packed {
    logic [1:0] cnt;
    qpd_out_t   r0;
    qpd_out_t   r1;
  } qpd_res_t;

  // Non-digits decode as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/qpd_core.sv
// Escape state and per-item decode for the quoted-printable decoder.
// Depends on qpd_pkg.
`default_nettype none

module qpd_core import qpd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step,
  input  wire qpd_in_t  item,
  output qpd_res_t      res
);

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;

  always_comb begin
    phase_nxt = PHASE_IDLE;
    held_nxt  = held_r;
    res.cnt   = 2'd0;
    res.r0    = '{out_byte: item.in_byte, run_last: 1'b1};
    res.r1    = '{out_byte: item.in_byte, run_last: 1'b1};
    unique case (phase_r)
      PHASE_EQ: begin
        if (item.in_last) begin
          // The message ends inside the escape: both bytes pass literally.
          res.cnt = 2'd2;
          res.r0  = '{out_byte: CH_EQUAL, run_last: 1'b0};
        end else begin
          held_nxt  = item.in_byte;
          phase_nxt = PHASE_DIGIT;
        end
      end
      PHASE_DIGIT: begin
        if (!(held_r == CH_CR && item.in_byte == CH_LF)) begin
          res.cnt = 2'd1;
          res.r0  = '{out_byte: {hex_value(held_r), hex_value(item.in_byte)},
                      run_last: 1'b1};
        end
      end
      default: begin
        if (item.in_byte == CH_EQUAL && !item.in_last) begin
          phase_nxt = PHASE_EQ;
        end else begin
          res.cnt = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_IDLE;
      held_r  <= 8'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/qpd_res_fifo.sv
// Result queue for the quoted-printable decoder: takes up to two items a cycle,
// gives at most one. Depends on qpd_pkg.
`default_nettype none

module qpd_res_fifo import qpd_pkg::*; #(
  parameter int DEPTH = QPD_FIFO_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_en,
  input  wire qpd_res_t  push,
  output logic           room2,
  input  wire logic      pop,
  output logic           head_valid,
  output qpd_out_t       head
);

  localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int CW1 = CW + 1;

  qpd_out_t        mem_r [DEPTH];
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, wr_ptr1;
  logic [CW-1:0]   count_r, count_nxt;
  logic [1:0]      n_push;
  logic            pop_en;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign pop_en     = head_valid && pop;
  assign n_push     = push_en ? push.cnt : 2'd0;
  assign wr_ptr1    = ptr_inc(wr_ptr_r);

  // Room for two more items, counting the slot freed by this cycle's pop.
  assign room2 = (CW1'(count_r) + CW1'(2)) <= (CW1'(DEPTH) + CW1'(pop_en));

  always_comb begin
    count_nxt  = count_r + CW'(n_push) - CW'(pop_en);
    rd_ptr_nxt = pop_en ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    unique case (n_push)
      2'd0:    wr_ptr_nxt = wr_ptr_r;
      2'd1:    wr_ptr_nxt = wr_ptr1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
    end else begin
      count_r  <= count_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_ptr1] <= push.r1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/quoted_printable_decoder_unit.sv
// Quoted-printable decoder, top level: input register, decode and result queue.
// Depends on qpd_pkg, qpd_core and qpd_res_fifo.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) takes one encoded byte per
//   item, with in_last on the final byte of a message. The result channel
//   (out_valid, out_stall, out_data) gives the decoded bytes; run_last marks
//   the last result that one input item causes. An input item gives zero, one
//   or two results.
//   A result passes through the input register and then the result queue
//   before it is offered at the output.
//   Throughput: one input item per cycle while results are taken as fast as
//   they come; the result port moves one item per cycle while out_stall is
//   low, so items that give two results let the queue grow. The input register
//   hands an item to the decoder only when the result queue has two free
//   slots; that queue (FIFO_DEPTH entries) sets how far the output may stall
//   before in_stall rises.
//   Reset (synchronous, rst_n low) empties the input register and the queue
//   and clears the escape state. A stall on the output fills the queue and
//   then back-pressures the input; no item is lost.
`default_nettype none

module quoted_printable_decoder_unit import qpd_pkg::*; #(
  parameter int FIFO_DEPTH = QPD_FIFO_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire qpd_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output qpd_out_t      out_data
);

  logic      in_valid_r, in_valid_nxt;
  qpd_in_t   in_r;
  logic      room2;
  logic      consume;
  logic      accept;
  qpd_res_t  res;

  assign consume  = in_valid_r && room2;
  assign in_stall = in_valid_r && !room2;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (consume) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
  end

  qpd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (consume),
    .item  (in_r),
    .res   (res)
  );

  qpd_res_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_en    (consume),
    .push       (res),
    .room2      (room2),
    .pop        (!out_stall),
    .head_valid (out_valid),
    .head       (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/qpd_checker.sv
// Port-level checks for the quoted-printable decoder, bound to the top level.
// Depends on qpd_pkg and quoted_printable_decoder_unit_defines.svh.
`default_nettype none
`include "quoted_printable_decoder_unit_defines.svh"

module qpd_checker import qpd_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire qpd_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire qpd_out_t out_data
);

  // A stalled result item stays offered and unchanged.
  `QPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result item changed")

  // Reset empties the queue, so nothing is offered right after a reset cycle.
  `QPD_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "result offered after reset")

  // The input can only start stalling right after an item was taken.
  `QPD_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(in_valid), "input stall without a held item")

  // A stalled input item stays offered and unchanged.
  `QPD_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data), "stalled input item changed")

endmodule

bind quoted_printable_decoder_unit qpd_checker u_qpd_checker (.*);

`default_nettype wire
